/* design/vpfa_pkg.sv */
`timescale 1ns / 1ps
package vpfa_pkg;

    localparam logic [14:0] HdrLen         = 15'd12;
    localparam logic [15:0] MaxPacketBytes = 16'd16384;
    localparam logic [7:0]  FlagToggle     = 8'h01;
    localparam logic [7:0]  FlagError      = 8'h40;
    localparam logic [23:0] FrameBytesRst  = 24'd1228800;
    localparam int          FifoDepth      = 4;
    localparam int          FifoPtrW       = $clog2(FifoDepth);

    typedef enum logic [1:0] {
        KIND_WRITE     = 2'd0,
        KIND_COMPLETE  = 2'd1,
        KIND_DROP      = 2'd2,
        KIND_NEW_FRAME = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        DROP_NONE     = 2'd0,
        DROP_BAD      = 2'd1,
        DROP_ERROR    = 2'd2,
        DROP_OVERFLOW = 2'd3
    } t_drop;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] write_address;
        logic [7:0]  write_data;
        logic [31:0] timestamp;
        t_drop       drop_reason;
        logic        short_previous;
        logic        timestamp_jump;
        logic [23:0] fill_count;
    } t_result;

    // up to two results per byte, slot 0 first
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

endpackage

/* design/vpfa_in_if.sv */
`timescale 1ns / 1ps
interface vpfa_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [14:0] packet_length;

    modport source (output valid, output data_byte, output packet_length, input ready);
    modport sink   (input valid, input data_byte, input packet_length, output ready);
endinterface

/* design/vpfa_out_if.sv */
`timescale 1ns / 1ps
interface vpfa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [23:0] write_address;
    logic [7:0]  write_data;
    logic [31:0] timestamp;
    logic [1:0]  drop_reason;
    logic        short_previous;
    logic        timestamp_jump;
    logic [23:0] fill_count;

    modport source (
        output valid, output kind, output write_address, output write_data,
        output timestamp, output drop_reason, output short_previous,
        output timestamp_jump, output fill_count, input ready
    );
    modport sink (
        input valid, input kind, input write_address, input write_data,
        input timestamp, input drop_reason, input short_previous,
        input timestamp_jump, input fill_count, output ready
    );
endinterface

/* design/vpfa_core.sv */
`timescale 1ns / 1ps
module vpfa_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [23:0]        i_frame_bytes,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic [14:0]        i_packet_length,
    input  logic               i_room2,
    output vpfa_pkg::t_push    o_push
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [14:0] r_in_len;

    logic [14:0] r_pos,     n_pos;
    logic [7:0]  r_hls,     n_hls;
    logic [7:0]  r_flags,   n_flags;
    logic [31:0] r_tg,      n_tg;
    logic        r_toggle,  n_toggle;
    logic [31:0] r_held,    n_held;
    logic [23:0] r_fill,    n_fill;
    logic        r_discard, n_discard;
    logic        r_jump,    n_jump;

    logic            w_proc;
    logic            w_last;
    logic [14:0]     w_plen;
    logic [31:0]     w_held1;
    logic            w_nf;
    logic            w_tsdiff;
    logic [23:0]     w_fill2;
    logic            w_jump2;
    logic            w_ov;
    logic [23:0]     w_fill_inc;
    vpfa_pkg::t_push w_push;

    function automatic vpfa_pkg::t_result mk_res(
        input vpfa_pkg::t_kind kind,
        input logic [23:0]     addr,
        input logic [7:0]      data,
        input logic [31:0]     ts,
        input vpfa_pkg::t_drop reason,
        input logic            shortp,
        input logic            jump,
        input logic [23:0]     fill
    );
        vpfa_pkg::t_result res;
        res.kind           = kind;
        res.write_address  = addr;
        res.write_data     = data;
        res.timestamp      = ts;
        res.drop_reason    = reason;
        res.short_previous = shortp;
        res.timestamp_jump = jump;
        res.fill_count     = fill;
        return res;
    endfunction

    assign w_proc  = r_in_valid & i_room2;
    assign o_ready = i_rst_n & (!r_in_valid | w_proc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_len  <= i_packet_length;
        end
    end

    // header decisions
    assign w_last     = ({1'b0, r_pos} + 16'd1) >= {1'b0, r_in_len};
    assign w_plen     = r_in_len - vpfa_pkg::HdrLen;
    assign w_held1    = (r_fill == 24'd0) ? r_tg : r_held;
    assign w_nf       = ((r_flags & vpfa_pkg::FlagToggle) != 8'd0) != r_toggle;
    assign w_tsdiff   = r_tg != w_held1;
    assign w_fill2    = w_nf ? 24'd0 : r_fill;
    assign w_jump2    = r_jump | (!w_nf & w_tsdiff);
    assign w_ov       = ({1'b0, w_fill2} + {10'd0, w_plen}) > {1'b0, i_frame_bytes};
    assign w_fill_inc = r_fill + 24'd1;

    always_comb begin
        n_pos     = r_pos;
        n_hls     = r_hls;
        n_flags   = r_flags;
        n_tg      = r_tg;
        n_toggle  = r_toggle;
        n_held    = r_held;
        n_fill    = r_fill;
        n_discard = r_discard;
        n_jump    = r_jump;
        w_push    = '0;
        if (r_in_len == 15'd0) begin
            n_pos     = 15'd0;
            n_discard = 1'b0;
            n_jump    = 1'b0;
        end else begin
            if (!r_discard) begin
                case (r_pos)
                    15'd0:   n_hls   = r_in_byte;
                    15'd1:   n_flags = r_in_byte;
                    15'd2:   n_tg    = {24'd0, r_in_byte};
                    15'd3:   n_tg    = r_tg | {16'd0, r_in_byte, 8'd0};
                    15'd4:   n_tg    = r_tg | {8'd0, r_in_byte, 16'd0};
                    15'd5:   n_tg    = r_tg | {r_in_byte, 24'd0};
                    default: n_tg    = r_tg;
                endcase

                if (r_in_len < vpfa_pkg::HdrLen) begin
                    if (w_last) begin
                        w_push.count = 2'd1;
                        w_push.slot0 = mk_res(vpfa_pkg::KIND_DROP, 24'd0, 8'd0, r_held,
                                              vpfa_pkg::DROP_BAD, 1'b0, 1'b0, r_fill);
                    end
                end else if (r_in_len == vpfa_pkg::HdrLen) begin
                    n_discard = r_discard;
                end else if (r_pos == vpfa_pkg::HdrLen - 15'd1) begin
                    if (r_hls != vpfa_pkg::HdrLen[7:0] ||
                        {1'b0, r_in_len} > vpfa_pkg::MaxPacketBytes) begin
                        w_push.count = 2'd1;
                        w_push.slot0 = mk_res(vpfa_pkg::KIND_DROP, 24'd0, 8'd0, r_held,
                                              vpfa_pkg::DROP_BAD, 1'b0, 1'b0, r_fill);
                        n_discard    = 1'b1;
                    end else if ((r_flags & vpfa_pkg::FlagError) != 8'd0) begin
                        w_push.count = 2'd1;
                        w_push.slot0 = mk_res(vpfa_pkg::KIND_DROP, 24'd0, 8'd0, r_held,
                                              vpfa_pkg::DROP_ERROR, 1'b0, 1'b0, r_fill);
                        n_discard    = 1'b1;
                    end else begin
                        n_held = r_tg;
                        n_fill = w_fill2;
                        n_jump = w_jump2;
                        if (w_nf) begin
                            n_toggle     = !r_toggle;
                            w_push.count = 2'd1;
                            w_push.slot0 = mk_res(vpfa_pkg::KIND_NEW_FRAME, 24'd0, 8'd0,
                                                  r_tg, vpfa_pkg::DROP_NONE,
                                                  r_fill != i_frame_bytes, 1'b0, r_fill);
                        end
                        if (w_ov) begin
                            n_jump    = 1'b0;
                            n_discard = 1'b1;
                            if (w_nf) begin
                                w_push.count = 2'd2;
                                w_push.slot1 = mk_res(vpfa_pkg::KIND_DROP, 24'd0, 8'd0, r_tg,
                                                      vpfa_pkg::DROP_OVERFLOW, 1'b0,
                                                      w_jump2, w_fill2);
                            end else begin
                                w_push.count = 2'd1;
                                w_push.slot0 = mk_res(vpfa_pkg::KIND_DROP, 24'd0, 8'd0, r_tg,
                                                      vpfa_pkg::DROP_OVERFLOW, 1'b0,
                                                      w_jump2, w_fill2);
                            end
                        end
                    end
                end else if (r_pos >= vpfa_pkg::HdrLen) begin
                    n_jump = 1'b0;
                    if (r_fill >= i_frame_bytes) begin
                        w_push.count = 2'd1;
                        w_push.slot0 = mk_res(vpfa_pkg::KIND_DROP, 24'd0, 8'd0, r_held,
                                              vpfa_pkg::DROP_OVERFLOW, 1'b0, r_jump, r_fill);
                        n_discard    = 1'b1;
                    end else begin
                        n_fill       = w_fill_inc;
                        w_push.count = 2'd1;
                        w_push.slot0 = mk_res(vpfa_pkg::KIND_WRITE, r_fill, r_in_byte, r_held,
                                              vpfa_pkg::DROP_NONE, 1'b0, r_jump, w_fill_inc);
                        if (w_fill_inc == i_frame_bytes) begin
                            w_push.count = 2'd2;
                            w_push.slot1 = mk_res(vpfa_pkg::KIND_COMPLETE, 24'd0, 8'd0,
                                                  r_held, vpfa_pkg::DROP_NONE, 1'b0, 1'b0,
                                                  w_fill_inc);
                        end
                    end
                end
            end

            if (w_last) begin
                n_pos     = 15'd0;
                n_discard = 1'b0;
                n_jump    = 1'b0;
            end else begin
                n_pos = r_pos + 15'd1;
            end
        end
    end

    always_comb begin
        o_push = w_push;
        if (!w_proc) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hls     <= '0;
            r_flags   <= '0;
            r_tg      <= '0;
            r_toggle  <= 1'b0;
            r_held    <= '0;
            r_fill    <= '0;
            r_discard <= 1'b0;
            r_jump    <= 1'b0;
        end else if (w_proc) begin
            r_pos     <= n_pos;
            r_hls     <= n_hls;
            r_flags   <= n_flags;
            r_tg      <= n_tg;
            r_toggle  <= n_toggle;
            r_held    <= n_held;
            r_fill    <= n_fill;
            r_discard <= n_discard;
            r_jump    <= n_jump;
        end
    end

endmodule

/* design/vpfa_res_fifo.sv */
`timescale 1ns / 1ps
module vpfa_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vpfa_pkg::t_push   i_push,
    output logic              o_room2,
    output logic              o_valid,
    input  logic              i_ready,
    output vpfa_pkg::t_result o_data
);

    localparam int PtrW = vpfa_pkg::FifoPtrW;
    localparam int CntW = PtrW + 1;

    vpfa_pkg::t_result r_mem [vpfa_pkg::FifoDepth];
    logic [PtrW-1:0]   r_wp, n_wp;
    logic [PtrW-1:0]   r_rp, n_rp;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              w_pop;
    logic [PtrW-1:0]   w_wp1;

    assign w_pop   = o_valid & i_ready;
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign o_room2 = r_cnt <= CntW'(vpfa_pkg::FifoDepth - 2);
    assign w_wp1   = r_wp + PtrW'(1);

    always_comb begin
        n_wp  = r_wp + PtrW'(i_push.count);
        n_rp  = w_pop ? r_rp + PtrW'(1) : r_rp;
        n_cnt = r_cnt + CntW'(i_push.count) - CntW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wp1] <= i_push.slot1;
        end
    end

endmodule

/* design/video_payload_frame_assembler.sv */
`timescale 1ns / 1ps
// Reassembles a video frame from isochronous packets given one byte per beat with the
// packet length on every beat. Each accepted byte is registered and decoded once the result
// queue has room for two entries; its events (byte write, frame complete, packet drop, new
// frame) enter a four-entry result queue and are offered to the sink from there. The
// input takes one byte per cycle while the queue has two free entries, and holds ready low
// during reset. The output moves one result per cycle while the sink is ready, so a byte
// that yields two results (last payload byte plus frame complete, or new frame plus overflow
// drop) pushes both at once; a run of such bytes, or a stalled sink, fills the queue and
// holds off the input. The user must write frame_bytes through i_cfg_wr_en/i_cfg_wr_data
// only while no bytes are in flight; the block does not enforce this.
module video_payload_frame_assembler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [23:0]       i_cfg_wr_data,
    vpfa_in_if.sink           i_in,
    vpfa_out_if.source        o_out
);

    logic [23:0]       r_frame_bytes;
    logic              w_room2;
    vpfa_pkg::t_push   w_push;
    vpfa_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= vpfa_pkg::FrameBytesRst;
        end else if (i_cfg_wr_en) begin
            r_frame_bytes <= i_cfg_wr_data;
        end
    end

    vpfa_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_bytes   (r_frame_bytes),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_data_byte     (i_in.data_byte),
        .i_packet_length (i_in.packet_length),
        .i_room2         (w_room2),
        .o_push          (w_push)
    );

    vpfa_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room2 (w_room2),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_res)
    );

    assign o_out.kind           = w_res.kind;
    assign o_out.write_address  = w_res.write_address;
    assign o_out.write_data     = w_res.write_data;
    assign o_out.timestamp      = w_res.timestamp;
    assign o_out.drop_reason    = w_res.drop_reason;
    assign o_out.short_previous = w_res.short_previous;
    assign o_out.timestamp_jump = w_res.timestamp_jump;
    assign o_out.fill_count     = w_res.fill_count;

endmodule

/* tb/sv/video_payload_frame_assembler_tb.sv */
`timescale 1ns / 1ps
module video_payload_frame_assembler_tb;
    import vpfa_pkg::*;

    localparam int          CYCLE_LIMIT  = 3_000_000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          DRAIN_GUARD  = 20_000;
    localparam int          TOTAL_BEATS  = 1900;
    localparam int          PHASE_BEATS  = 300;
    localparam logic [7:0]  HDR_BYTE     = 8'(HdrLen);

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TRICKLE, RX_HICCUP} rx_mode_t;
    typedef enum logic {ROW_PACKET, ROW_FRAME_SIZE} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE_DROP} row_check_t;

    typedef struct {
        row_kind_t   what;
        logic [23:0] size_val;
        logic [7:0]  hdr_len;
        logic [7:0]  flags;
        logic [31:0] pts;
        logic [14:0] len;
        logic [14:0] len_late;
        int          late_from;
        int          cut_at;
        row_check_t  check;
        t_drop       reason;
        logic [31:0] want_ts;
        logic [23:0] want_fill;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [23:0] cfg_wr_data;

    vpfa_in_if  byte_if ();
    vpfa_out_if event_if ();

    video_payload_frame_assembler u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (byte_if),
        .o_out         (event_if)
    );

    always #5 clk = ~clk;

    // frame assembly state, mirrored
    logic [23:0] frame_goal     = FrameBytesRst;
    logic [14:0] pkt_pos        = '0;
    logic [7:0]  hdr_len_byte   = '0;
    logic [7:0]  hdr_flags_byte = '0;
    logic [31:0] pts_gather     = '0;
    logic        toggle_now     = 1'b0;
    logic [31:0] pts_held       = '0;
    logic [23:0] fill_now       = '0;
    logic        pkt_dropping   = 1'b0;
    logic        jump_held      = 1'b0;

    t_result     expected_events[$];
    plan_row_t   plan[$];
    bit          row_typed   = 1'b0;
    int          typed_left  = 0;
    t_result     typed_event;

    int          fail_count  = 0;
    int          events_seen = 0;
    int          beats_sent  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;
    int          rx_tick     = 0;
    rx_mode_t    rx_mode     = RX_OPEN;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_count++;
        if (fail_count <= 60)
            $display("%0t: %s expected 0x%0h got 0x%0h (event %0d)",
                     $time, what, want, got, events_seen);
    endtask

    function void post_event(t_kind k, logic [23:0] addr, logic [7:0] d, t_drop r,
                             logic shortp, logic jump, logic [23:0] fill);
        t_result e;
        e.kind           = k;
        e.write_address  = addr;
        e.write_data     = d;
        e.timestamp      = pts_held;
        e.drop_reason    = r;
        e.short_previous = shortp;
        e.timestamp_jump = jump;
        e.fill_count     = fill;
        if (row_typed) begin
            if (typed_left > 0)
                expected_events.push_back(typed_event);
            typed_left--;
        end else begin
            expected_events.push_back(e);
        end
    endfunction

    function void settle_header(logic [14:0] len);
        logic [31:0] payload;
        logic [23:0] old_fill;
        logic        toggle;
        if (hdr_len_byte != HDR_BYTE || {1'b0, len} > MaxPacketBytes) begin
            post_event(KIND_DROP, '0, '0, DROP_BAD, 1'b0, 1'b0, fill_now);
            pkt_dropping = 1'b1;
            return;
        end
        if ((hdr_flags_byte & FlagError) != 0) begin
            post_event(KIND_DROP, '0, '0, DROP_ERROR, 1'b0, 1'b0, fill_now);
            pkt_dropping = 1'b1;
            return;
        end
        if (fill_now == 0)
            pts_held = pts_gather;
        toggle = (hdr_flags_byte & FlagToggle) != 0;
        if (toggle != toggle_now) begin
            old_fill   = fill_now;
            toggle_now = toggle;
            pts_held   = pts_gather;
            fill_now   = '0;
            post_event(KIND_NEW_FRAME, '0, '0, DROP_NONE, old_fill != frame_goal, 1'b0,
                       old_fill);
        end else if (pts_gather != pts_held) begin
            pts_held  = pts_gather;
            jump_held = 1'b1;
        end
        payload = 32'(len) - 32'(HdrLen);
        if (32'(fill_now) + payload > 32'(frame_goal)) begin
            post_event(KIND_DROP, '0, '0, DROP_OVERFLOW, 1'b0, jump_held, fill_now);
            jump_held    = 1'b0;
            pkt_dropping = 1'b1;
        end
    endfunction

    function void place_byte(logic [7:0] b);
        logic [23:0] addr;
        if (fill_now >= frame_goal) begin
            post_event(KIND_DROP, '0, '0, DROP_OVERFLOW, 1'b0, jump_held, fill_now);
            jump_held    = 1'b0;
            pkt_dropping = 1'b1;
            return;
        end
        addr     = fill_now;
        fill_now = fill_now + 24'd1;
        post_event(KIND_WRITE, addr, b, DROP_NONE, 1'b0, jump_held, fill_now);
        jump_held = 1'b0;
        if (fill_now == frame_goal)
            post_event(KIND_COMPLETE, '0, '0, DROP_NONE, 1'b0, 1'b0, fill_now);
    endfunction

    function void assemble_byte(logic [7:0] b, logic [14:0] len);
        logic [14:0] pos;
        bit          last;
        pos = pkt_pos;
        if (len == 0) begin
            pkt_pos      = '0;
            pkt_dropping = 1'b0;
            jump_held    = 1'b0;
            return;
        end
        last = (int'(pos) + 1 >= int'(len));
        if (!pkt_dropping) begin
            if (pos == 0)
                hdr_len_byte = b;
            else if (pos == 1)
                hdr_flags_byte = b;
            else if (pos == 2)
                pts_gather = {24'd0, b};
            else if (pos <= 5)
                pts_gather = pts_gather | ({24'd0, b} << (8 * (pos - 2)));

            if (len < HdrLen) begin
                if (last)
                    post_event(KIND_DROP, '0, '0, DROP_BAD, 1'b0, 1'b0, fill_now);
            end else if (len > HdrLen && pos == HdrLen - 1) begin
                settle_header(len);
            end else if (len > HdrLen && pos >= HdrLen) begin
                place_byte(b);
            end
        end
        if (last) begin
            pkt_pos      = '0;
            pkt_dropping = 1'b0;
            jump_held    = 1'b0;
        end else begin
            pkt_pos = pos + 15'd1;
        end
    endfunction

    function void add_size(logic [23:0] v);
        plan_row_t row;
        row.what     = ROW_FRAME_SIZE;
        row.size_val = v;
        plan.push_back(row);
    endfunction

    function void add_packet(logic [7:0] hl, logic [7:0] fl, logic [31:0] pts,
                             logic [14:0] len, logic [14:0] len_late, int late_from,
                             int cut_at, logic [23:0] cut_size, row_check_t check,
                             t_drop reason, logic [31:0] want_ts, logic [23:0] want_fill);
        plan_row_t row;
        row.what       = ROW_PACKET;
        row.size_val   = cut_size;
        row.hdr_len    = hl;
        row.flags      = fl;
        row.pts        = pts;
        row.len        = len;
        row.len_late   = len_late;
        row.late_from  = late_from;
        row.cut_at     = cut_at;
        row.check      = check;
        row.reason     = reason;
        row.want_ts    = want_ts;
        row.want_fill  = want_fill;
        plan.push_back(row);
    endfunction

    task automatic wait_drained;
        int guard;
        guard = 0;
        while (expected_events.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [23:0] v);
        byte_if.valid <= 1'b0;
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        frame_goal = v;
    endtask

    task automatic send_beat(input logic [7:0] b, input logic [14:0] len);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_if.valid         <= 1'b1;
        byte_if.data_byte     <= b;
        byte_if.packet_length <= len;
        do begin
            @(posedge clk);
        end while (byte_if.ready !== 1'b1);
        beats_sent++;
        assemble_byte(b, len);
    endtask

    task automatic send_packet(input logic [7:0] hl, input logic [7:0] fl,
                               input logic [31:0] pts, input logic [14:0] len,
                               input logic [14:0] len_late, input int late_from,
                               input int cut_at, input logic [23:0] cut_size);
        int          i;
        logic [14:0] len_now;
        logic [7:0]  b;
        bit          done;
        i    = 0;
        done = 1'b0;
        while (!done) begin
            len_now = (late_from != 0 && i >= late_from) ? len_late : len;
            if (cut_at != 0 && i == cut_at)
                write_frame_size(cut_size);
            if (i == 0)
                b = hl;
            else if (i == 1)
                b = fl;
            else if (i <= 5)
                b = pts[8 * (i - 2) +: 8];
            else
                b = 8'($urandom_range(0, 255));
            send_beat(b, len_now);
            i++;
            done = (len_now == 0) || (i >= int'(len_now));
        end
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        rx_tick     <= rx_tick + 1;
        if (rx_tick % 128 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:    event_if.ready <= 1'b1;
            RX_COIN:    event_if.ready <= 1'($urandom_range(0, 1));
            RX_TRICKLE: event_if.ready <= (rx_tick % 4 == 3);
            default:    event_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk) begin : check_events
        t_result want;
        if (rst_n === 1'b1 && event_if.valid === 1'b1 && event_if.ready === 1'b1) begin
            events_seen++;
            if (expected_events.size() == 0) begin
                report_mismatch("event with nothing pending, kind", 0, event_if.kind);
            end else begin
                want = expected_events.pop_front();
                if (event_if.kind !== want.kind)
                    report_mismatch("kind", want.kind, event_if.kind);
                if (event_if.write_address !== want.write_address)
                    report_mismatch("write_address", want.write_address,
                                    event_if.write_address);
                if (event_if.write_data !== want.write_data)
                    report_mismatch("write_data", want.write_data, event_if.write_data);
                if (event_if.timestamp !== want.timestamp)
                    report_mismatch("timestamp", want.timestamp, event_if.timestamp);
                if (event_if.drop_reason !== want.drop_reason)
                    report_mismatch("drop_reason", want.drop_reason, event_if.drop_reason);
                if (event_if.short_previous !== want.short_previous)
                    report_mismatch("short_previous", want.short_previous,
                                    event_if.short_previous);
                if (event_if.timestamp_jump !== want.timestamp_jump)
                    report_mismatch("timestamp_jump", want.timestamp_jump,
                                    event_if.timestamp_jump);
                if (event_if.fill_count !== want.fill_count)
                    report_mismatch("fill_count", want.fill_count, event_if.fill_count);
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int          phase;
        int          next_phase;
        int          r;
        int          payload;
        int          late_from;
        logic [7:0]  hl;
        logic [7:0]  fl;
        logic [14:0] len;
        logic [14:0] len_late;
        logic        gen_toggle;
        logic [31:0] gen_pts;
        logic [23:0] size_pick;

        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_wr_data           <= '0;
        byte_if.valid         <= 1'b0;
        byte_if.data_byte     <= '0;
        byte_if.packet_length <= '0;

        // drops right after reset: held timestamp and fill are still zero
        add_packet(8'hFF, 8'h00, 32'h0, 15'd0, 15'd0, 0, 0, 24'd0,
                   CHK_NONE, DROP_NONE, 32'h0, 24'd0);
        add_packet(8'hFF, 8'h00, 32'h0, 15'd1, 15'd0, 0, 0, 24'd0,
                   CHK_ONE_DROP, DROP_BAD, 32'h0, 24'd0);
        add_packet(HDR_BYTE, 8'h00, 32'hFFFF_FFFF, 15'd11, 15'd0, 0, 0, 24'd0,
                   CHK_ONE_DROP, DROP_BAD, 32'h0, 24'd0);
        add_packet(HDR_BYTE, 8'h41, 32'hFFFF_FFFF, 15'd12, 15'd0, 0, 0, 24'd0,
                   CHK_NONE, DROP_NONE, 32'h0, 24'd0);
        add_packet(8'h00, 8'h00, 32'h0, 15'd13, 15'd0, 0, 0, 24'd0,
                   CHK_ONE_DROP, DROP_BAD, 32'h0, 24'd0);
        add_packet(HDR_BYTE, FlagError, 32'h0, 15'd13, 15'd0, 0, 0, 24'd0,
                   CHK_ONE_DROP, DROP_ERROR, 32'h0, 24'd0);
        add_packet(HDR_BYTE, 8'hFF, 32'h0, 15'd13, 15'd0, 0, 0, 24'd0,
                   CHK_ONE_DROP, DROP_ERROR, 32'h0, 24'd0);
        add_packet(HDR_BYTE, 8'h00, 32'h0, 15'd16385, 15'd13, 12, 0, 24'd0,
                   CHK_ONE_DROP, DROP_BAD, 32'h0, 24'd0);
        add_packet(HDR_BYTE, 8'h00, 32'h0, 15'd32767, 15'd13, 12, 0, 24'd0,
                   CHK_ONE_DROP, DROP_BAD, 32'h0, 24'd0);
        add_size(24'd0);
        add_packet(HDR_BYTE, 8'h00, 32'h5, 15'd14, 15'd0, 0, 0, 24'd0,
                   CHK_ONE_DROP, DROP_OVERFLOW, 32'h5, 24'd0);
        add_size(24'd8);
        add_packet(HDR_BYTE, 8'hBF, 32'hFFFF_FFFF, 15'd15, 15'd0, 0, 0, 24'd0,
                   CHK_MODEL, DROP_NONE, 32'h0, 24'd0);
        add_packet(HDR_BYTE, 8'h01, 32'h1234_5678, 15'd17, 15'd0, 0, 0, 24'd0,
                   CHK_MODEL, DROP_NONE, 32'h0, 24'd0);
        add_packet(HDR_BYTE, 8'h01, 32'h1234_5678, 15'd13, 15'd0, 0, 0, 24'd0,
                   CHK_MODEL, DROP_NONE, 32'h0, 24'd0);
        add_packet(HDR_BYTE, 8'h00, 32'h0, 15'd14, 15'd0, 0, 0, 24'd0,
                   CHK_MODEL, DROP_NONE, 32'h0, 24'd0);
        add_packet(HDR_BYTE, 8'h00, 32'hA5A5_A5A5, 15'd32, 15'd0, 0, 0, 24'd0,
                   CHK_MODEL, DROP_NONE, 32'h0, 24'd0);
        add_packet(HDR_BYTE, 8'h01, 32'h7, 15'd30, 15'd0, 0, 0, 24'd0,
                   CHK_MODEL, DROP_NONE, 32'h0, 24'd0);
        add_size(24'd64);
        // frame size cut below the fill partway through the payload
        add_packet(HDR_BYTE, 8'h00, 32'h9, 15'd22, 15'd0, 0, 16, 24'd2,
                   CHK_MODEL, DROP_NONE, 32'h0, 24'd0);
        add_size(24'hFF_FFFF);
        add_packet(HDR_BYTE, 8'h00, 32'h9, 15'd40, 15'd15, 13, 0, 24'd0,
                   CHK_MODEL, DROP_NONE, 32'h0, 24'd0);
        // empty beat abandons the packet in progress
        add_packet(HDR_BYTE, 8'h01, 32'hB, 15'd20, 15'd0, 15, 0, 24'd0,
                   CHK_MODEL, DROP_NONE, 32'h0, 24'd0);
        // largest legal length at the header, cut short after it
        add_packet(HDR_BYTE, 8'h00, 32'h3, 15'd16384, 15'd14, 12, 0, 24'd0,
                   CHK_MODEL, DROP_NONE, 32'h0, 24'd0);
        add_size(FrameBytesRst);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].what == ROW_FRAME_SIZE) begin
                write_frame_size(plan[k].size_val);
            end else begin
                row_typed                  = (plan[k].check != CHK_MODEL);
                typed_left                 = (plan[k].check == CHK_ONE_DROP) ? 1 : 0;
                typed_event.kind           = KIND_DROP;
                typed_event.write_address  = '0;
                typed_event.write_data     = '0;
                typed_event.timestamp      = plan[k].want_ts;
                typed_event.drop_reason    = plan[k].reason;
                typed_event.short_previous = 1'b0;
                typed_event.timestamp_jump = 1'b0;
                typed_event.fill_count     = plan[k].want_fill;
                send_packet(plan[k].hdr_len, plan[k].flags, plan[k].pts, plan[k].len,
                            plan[k].len_late, plan[k].late_from, plan[k].cut_at,
                            plan[k].size_val);
                if (row_typed && typed_left != 0)
                    report_mismatch("directed packet event count", 0, typed_left);
                row_typed = 1'b0;
            end
        end

        phase      = 0;
        next_phase = beats_sent;
        gen_toggle = toggle_now;
        gen_pts    = $urandom;
        while (beats_sent < TOTAL_BEATS) begin
            if (beats_sent >= next_phase) begin
                case (phase)
                    0:       size_pick = 24'd1;
                    1:       size_pick = 24'd0;
                    2:       size_pick = 24'hFF_FFFF;
                    default: size_pick = 24'($urandom_range(1, 48));
                endcase
                write_frame_size(size_pick);
                phase++;
                next_phase = next_phase + PHASE_BEATS;
            end
            if ($urandom_range(0, 4) == 0) begin
                gen_toggle = ~gen_toggle;
                gen_pts    = $urandom;
            end else if ($urandom_range(0, 3) == 0) begin
                gen_pts = $urandom;
            end
            hl        = HDR_BYTE;
            fl        = (8'($urandom_range(0, 255)) & ~(FlagToggle | FlagError))
                        | {7'd0, gen_toggle};
            payload   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 80)
                                                    : $urandom_range(1, 12);
            len       = 15'(int'(HdrLen) + payload);
            len_late  = '0;
            late_from = 0;
            r = $urandom_range(0, 99);
            if (r < 4) begin
                len = '0;
            end else if (r < 8) begin
                len = 15'($urandom_range(1, 11));
                hl  = 8'($urandom_range(0, 255));
            end else if (r < 11) begin
                len = HdrLen;
            end else if (r < 14) begin
                hl = HDR_BYTE ^ 8'($urandom_range(1, 255));
            end else if (r < 18) begin
                fl = fl | FlagError;
            end else if (r < 21) begin
                late_from = $urandom_range(1, int'(len) - 1);
                len_late  = (r == 18) ? 15'd0 : 15'($urandom_range(1, 40));
            end
            send_packet(hl, fl, gen_pts, len, len_late, late_from, 0, 24'd0);
        end

        byte_if.valid <= 1'b0;
        wait_drained();
        if (expected_events.size() != 0)
            report_mismatch("events never produced", 0, expected_events.size());
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
